FILE: sv/arm_subset_execute_unit_defines.svh
// ----------------------------------------------------------------------------
// arm_subset_execute_unit_defines.svh
// Assertion macros shared by the checkers of the execute unit.
// ----------------------------------------------------------------------------
`ifndef ARM_SUBSET_EXECUTE_UNIT_DEFINES_SVH
`define ARM_SUBSET_EXECUTE_UNIT_DEFINES_SVH

// same-cycle implication, off while reset is high
`define ASE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define ASE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// condition that must hold in the cycle after any reset cycle
`define ASE_ASSERT_AFTER_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/ase_pkg.sv
// ----------------------------------------------------------------------------
// ase_pkg
// Constants, field layouts and types of the execute unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ase_pkg;

   // data memory geometry
   localparam int DATA_WORDS = 128;
   localparam int DMEM_AW    = $clog2(DATA_WORDS);
   localparam logic [31:0] DMEM_BYTES = 32'(4 * DATA_WORDS);

   // register file
   localparam int REG_COUNT = 15;
   localparam logic [3:0] REG_PC_IDX   = 4'd15;
   localparam logic [3:0] REG_LINK_IDX = 4'd14;

   // reset values
   localparam logic [15:0] CODE_BASE_RESET = 16'd1000;
   localparam logic [23:0] DATA_BASE_RESET = 24'd1000000;

   // post-reset clearing sweep covers data memory and register file
   localparam int CLEAR_WORDS = (DATA_WORDS > 16) ? DATA_WORDS : 16;
   localparam int CLR_W       = $clog2(CLEAR_WORDS);

   // operation codes
   localparam logic [3:0] OP_MOV  = 4'd0;
   localparam logic [3:0] OP_ADD  = 4'd1;
   localparam logic [3:0] OP_SUB  = 4'd2;
   localparam logic [3:0] OP_MUL  = 4'd3;
   localparam logic [3:0] OP_CMP  = 4'd4;
   localparam logic [3:0] OP_LDR  = 4'd5;
   localparam logic [3:0] OP_LDRA = 4'd6;
   localparam logic [3:0] OP_STR  = 4'd7;
   localparam logic [3:0] OP_B    = 4'd8;
   localparam logic [3:0] OP_BL   = 4'd9;
   localparam logic [3:0] OP_BNE  = 4'd10;
   localparam logic [3:0] OP_BGE  = 4'd11;
   localparam logic [3:0] OP_EXIT = 4'd12;

   // request word layout
   localparam int REQ_DEST_LSB = 0;
   localparam int REQ_A_LSB    = 4;
   localparam int REQ_B_LSB    = 36;
   localparam int REQ_TGT_LSB  = 68;
   localparam int REQ_USED_W   = 84;
   localparam int REQ_DATA_W   = ((REQ_USED_W + 7) / 8) * 8;

   // request sideband layout
   localparam int USER_OP_LSB   = 0;
   localparam int USER_AIMM_BIT = 4;
   localparam int USER_BIMM_BIT = 5;
   localparam int REQ_USER_W    = 6;

   // response word layout
   localparam int RSP_PC_LSB    = 0;
   localparam int RSP_WR_BIT    = 16;
   localparam int RSP_IDX_LSB   = 17;
   localparam int RSP_VAL_LSB   = 21;
   localparam int RSP_MW_BIT    = 53;
   localparam int RSP_MIDX_LSB  = 54;
   localparam int RSP_TAKEN_BIT = RSP_MIDX_LSB + DMEM_AW;
   localparam int RSP_FAULT_BIT = RSP_TAKEN_BIT + 1;
   localparam int RSP_HALT_BIT  = RSP_TAKEN_BIT + 2;
   localparam int RSP_USED_W    = RSP_TAKEN_BIT + 3;
   localparam int RSP_DATA_W    = ((RSP_USED_W + 7) / 8) * 8;

   // control register port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic CSR_SEL_CODE_BASE = 1'b0;
   localparam logic CSR_SEL_DATA_BASE = 1'b1;

   typedef struct packed {
      logic        en;
      logic [3:0]  idx;
      logic [31:0] value;
   } rf_wr_type;

   typedef struct packed {
      logic               we;
      logic               re;
      logic [DMEM_AW-1:0] addr;
      logic [31:0]        wdata;
   } dm_req_type;

   typedef struct packed {
      logic [3:0]  op;
      logic [3:0]  dest;
      logic        a_is_imm;
      logic [31:0] a_value;
      logic        b_is_imm;
      logic [31:0] b_value;
      logic [15:0] target;
   } insn_type;

   typedef struct packed {
      logic               wr;
      logic [3:0]         idx;
      logic               is_load;
      logic [31:0]        value;
      logic               mw;
      logic [DMEM_AW-1:0] midx;
      logic [15:0]        next_pc;
      logic               taken;
      logic               fault;
      logic               halted;
   } exec_type;

endpackage

`default_nettype wire

FILE: sv/arm_subset_execute_unit.sv
// ----------------------------------------------------------------------------
// arm_subset_execute_unit
// Executes one pre-decoded instruction of a small ARM-like subset per word.
//
// req_* carries one instruction per word, rsp_* returns one result word per
// instruction, in order. csr_* holds code_base and data_base; write them only
// while no instruction is in flight.
// A result passes stage 1 (execute), stage 2 (data memory access) and the
// output register before it appears on rsp_tvalid.
// Throughput: one instruction per cycle while rsp_tready and no sweep holds it;
// a load forwards its memory data to the next instruction through the second
// stage, so no bubbles are needed. The register file read and the data memory
// access are each a synchronous read and set the three-stage depth.
// Reset: pc returns to 1000, flags and halt clear, and a sweep over
// max(DATA_WORDS, 16) addresses (128 here) zeroes data memory and registers;
// req_tready stays low during it. Control writes are taken throughout.
// Receiver stall: the output register holds its word; the stages behind it
// keep filling their empty slots, so up to two more requests are accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arm_subset_execute_unit (
   input  logic                              clock,
   input  logic                              reset,
   // request: tdata = dest_reg, a_value, b_value, branch_target (from bit 0)
   // request: tuser = op, a_is_imm, b_is_imm (from bit 0)
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ase_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [ase_pkg::REQ_USER_W-1:0]    req_tuser,
   // response: tdata = next_pc, reg_written, reg_index, reg_value,
   //   mem_written, mem_index, branch_taken, fault, halted (from bit 0)
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ase_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // control registers
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ase_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [ase_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [ase_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                              csr_pready
);
   import ase_pkg::*;

   function automatic logic [3:0] port1_idx(input insn_type i);
      port1_idx = (i.op == OP_CMP || i.op == OP_STR) ? i.dest : i.b_value[3:0];
   endfunction

   function automatic logic [31:0] resolve(
      input logic [3:0]  idx,
      input logic [31:0] ram,
      input logic [15:0] pc,
      input logic        s2_hit,
      input logic [3:0]  s2_idx,
      input logic [31:0] s2_val,
      input logic        wb_hit,
      input logic [3:0]  wb_idx,
      input logic [31:0] wb_val
   );
      priority if (idx == REG_PC_IDX) begin
         resolve = {16'b0, pc};
      end else if (s2_hit && s2_idx == idx) begin
         resolve = s2_val;
      end else if (wb_hit && wb_idx == idx) begin
         resolve = wb_val;
      end else begin
         resolve = ram;
      end
   endfunction

   // control
   logic [23:0] data_base;

   // clearing sweep
   logic             clearing_ff, clearing_in;
   logic [CLR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic             clr_dm_hit, clr_rf_hit;

   // pipeline
   logic     s1_valid_ff, s1_valid_in;
   insn_type s1_ff, s1_in;
   logic     s2_valid_ff, s2_valid_in;
   exec_type s2_ff, s2_in;
   logic                  out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic out_adv, s2_adv, s1_adv, s1_move, s2_move, req_fire;

   // architectural state kept in flops
   logic [15:0] pc_ff, pc_in;
   logic        cz_ff, cz_in, cnn_ff, cnn_in, halt_ff, halt_in;

   // last register write, covers the read-old window of the register file
   logic        wb_valid_ff, wb_valid_in;
   logic [3:0]  wb_idx_ff, wb_idx_in;
   logic [31:0] wb_val_ff, wb_val_in;

   // memories
   logic [3:0]  rd_addr0, rd_addr1;
   logic [31:0] rd_data0, rd_data1, dm_rdata;
   insn_type    rd_src, req_item;
   rf_wr_type   rf_wr;
   dm_req_type  dm_req;

   // stage 1 datapath
   logic [31:0] s2_value, reg0, reg1, opa, opb, cmp_diff;
   logic [31:0] mem_addr, mem_off, ldra_value;
   logic [15:0] pc_plus;
   logic        addr_fault, cmp_upd, set_halt;
   logic [DMEM_AW-1:0] s1_midx;

   ase_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .data_base (data_base)
   );

   ase_regfile u_regfile (
      .clock    (clock),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (rd_data0),
      .rd_data1 (rd_data1),
      .wr       (rf_wr)
   );

   ase_data_mem u_data_mem (
      .clock (clock),
      .req   (dm_req),
      .rdata (dm_rdata)
   );

   // unpack request word
   always_comb begin
      req_item.op       = req_tuser[USER_OP_LSB +: 4];
      req_item.a_is_imm = req_tuser[USER_AIMM_BIT];
      req_item.b_is_imm = req_tuser[USER_BIMM_BIT];
      req_item.dest     = req_tdata[REQ_DEST_LSB +: 4];
      req_item.a_value  = req_tdata[REQ_A_LSB +: 32];
      req_item.b_value  = req_tdata[REQ_B_LSB +: 32];
      req_item.target   = req_tdata[REQ_TGT_LSB +: 16];
   end

   // stage advance, each slot fills when it is empty or drains
   assign out_adv    = !out_valid_ff || rsp_tready;
   assign s2_adv     = !s2_valid_ff || out_adv;
   assign s1_adv     = !s1_valid_ff || s2_adv;
   assign req_tready = s1_adv && !clearing_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign s1_move    = s1_valid_ff && s2_adv;
   assign s2_move    = s2_valid_ff && out_adv;

   // read every cycle for whatever sits in stage 1 next cycle
   assign rd_src   = s1_adv ? req_item : s1_ff;
   assign rd_addr0 = rd_src.a_value[3:0];
   assign rd_addr1 = port1_idx(rd_src);

   // stage 2 result value, load data forwards straight from the memory
   assign s2_value = s2_ff.is_load ? dm_rdata : s2_ff.value;

   assign reg0 = resolve(s1_ff.a_value[3:0], rd_data0, pc_ff, s2_valid_ff && s2_ff.wr,
                         s2_ff.idx, s2_value, wb_valid_ff, wb_idx_ff, wb_val_ff);
   assign reg1 = resolve(port1_idx(s1_ff), rd_data1, pc_ff, s2_valid_ff && s2_ff.wr,
                         s2_ff.idx, s2_value, wb_valid_ff, wb_idx_ff, wb_val_ff);

   assign opa        = s1_ff.a_is_imm ? s1_ff.a_value : reg0;
   assign opb        = s1_ff.b_is_imm ? s1_ff.b_value : reg1;
   assign cmp_diff   = reg1 - opa;
   assign mem_addr   = reg0 + s1_ff.b_value;
   assign mem_off    = mem_addr - {8'b0, data_base};
   assign addr_fault = (mem_off >= DMEM_BYTES);
   assign s1_midx    = mem_off[DMEM_AW+1:2];
   assign ldra_value = {8'b0, data_base} + {14'b0, s1_ff.target, 2'b00};
   assign pc_plus    = pc_ff + 16'd4;

   // stage 1 execute
   always_comb begin
      s2_in         = '0;
      s2_in.idx     = s1_ff.dest;
      s2_in.next_pc = pc_plus;
      cmp_upd       = 1'b0;
      set_halt      = 1'b0;
      if (halt_ff) begin
         s2_in.next_pc = pc_ff;
      end else begin
         unique case (s1_ff.op)
            OP_MOV: begin
               s2_in.wr    = 1'b1;
               s2_in.value = opa;
            end
            OP_ADD: begin
               s2_in.wr    = 1'b1;
               s2_in.value = opa + opb;
            end
            OP_SUB: begin
               s2_in.wr    = 1'b1;
               s2_in.value = opa - opb;
            end
            OP_MUL: begin
               s2_in.wr    = 1'b1;
               s2_in.value = opa * opb;
            end
            OP_CMP: cmp_upd = 1'b1;
            OP_LDR: begin
               if (addr_fault) begin
                  s2_in.fault = 1'b1;
               end else begin
                  s2_in.wr      = 1'b1;
                  s2_in.is_load = 1'b1;
                  s2_in.midx    = s1_midx;
               end
            end
            OP_LDRA: begin
               s2_in.wr    = 1'b1;
               s2_in.value = ldra_value;
            end
            OP_STR: begin
               if (addr_fault) begin
                  s2_in.fault = 1'b1;
               end else begin
                  s2_in.mw   = 1'b1;
                  s2_in.midx = s1_midx;
               end
            end
            OP_B:   s2_in.taken = 1'b1;
            OP_BL: begin
               s2_in.wr    = 1'b1;
               s2_in.idx   = REG_LINK_IDX;
               s2_in.value = {16'b0, pc_plus};
               s2_in.taken = 1'b1;
            end
            OP_BNE: s2_in.taken = !cz_ff;
            OP_BGE: s2_in.taken = cnn_ff;
            OP_EXIT: begin
               set_halt      = 1'b1;
               s2_in.next_pc = pc_ff;
            end
            default: ;
         endcase
      end
      // drop writes to the pc slot
      if (s2_in.wr && s2_in.idx == REG_PC_IDX) begin
         s2_in.wr = 1'b0;
      end
      if (!s2_in.wr) begin
         s2_in.idx     = '0;
         s2_in.value   = '0;
         s2_in.is_load = 1'b0;
      end
      if (s2_in.taken) begin
         s2_in.next_pc = s1_ff.target;
      end
      s2_in.halted = halt_ff || set_halt;
   end

   // architectural state advances as each instruction leaves stage 1
   always_comb begin
      pc_in   = pc_ff;
      cz_in   = cz_ff;
      cnn_in  = cnn_ff;
      halt_in = halt_ff;
      if (s1_move) begin
         pc_in   = s2_in.next_pc;
         halt_in = s2_in.halted;
         if (cmp_upd) begin
            cz_in  = (cmp_diff == 32'd0);
            cnn_in = !cmp_diff[31];
         end
      end
   end

   // pipeline registers
   assign s1_valid_in = s1_adv ? req_fire : s1_valid_ff;
   assign s1_in       = s1_adv ? req_item : s1_ff;
   assign s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;
   assign out_valid_in = out_adv ? s2_valid_ff : out_valid_ff;

   always_comb begin
      out_data_in = out_data_ff;
      if (out_adv) begin
         out_data_in = RSP_DATA_W'({s2_ff.halted, s2_ff.fault, s2_ff.taken, s2_ff.midx,
                                    s2_ff.mw, s2_value, s2_ff.idx, s2_ff.wr,
                                    s2_ff.next_pc});
      end
   end

   // clearing sweep
   assign clr_dm_hit  = {1'b0, clr_cnt_ff} < (CLR_W + 1)'(DATA_WORDS);
   assign clr_rf_hit  = {1'b0, clr_cnt_ff} < (CLR_W + 1)'(REG_COUNT);
   assign clearing_in = clearing_ff && (clr_cnt_ff != CLR_W'(CLEAR_WORDS - 1));
   assign clr_cnt_in  = clearing_ff ? clr_cnt_ff + CLR_W'(1) : clr_cnt_ff;

   // memory ports
   always_comb begin
      if (clearing_ff) begin
         rf_wr.en    = clr_rf_hit;
         rf_wr.idx   = clr_cnt_ff[3:0];
         rf_wr.value = '0;
         dm_req.we    = clr_dm_hit;
         dm_req.re    = 1'b0;
         dm_req.addr  = clr_cnt_ff[DMEM_AW-1:0];
         dm_req.wdata = '0;
      end else begin
         rf_wr.en    = s2_move && s2_ff.wr;
         rf_wr.idx   = s2_ff.idx;
         rf_wr.value = s2_value;
         dm_req.we    = s1_move && s2_in.mw;
         dm_req.re    = s2_adv;
         dm_req.addr  = s1_midx;
         dm_req.wdata = reg1;
      end
   end

   // track the latest pipeline register write
   assign wb_valid_in = (!clearing_ff && rf_wr.en) || wb_valid_ff;
   assign wb_idx_in   = (!clearing_ff && rf_wr.en) ? rf_wr.idx : wb_idx_ff;
   assign wb_val_in   = (!clearing_ff && rf_wr.en) ? rf_wr.value : wb_val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pc_ff        <= CODE_BASE_RESET;
         cz_ff        <= 1'b0;
         cnn_ff       <= 1'b0;
         halt_ff      <= 1'b0;
         wb_valid_ff  <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_cnt_ff   <= clr_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
         pc_ff        <= pc_in;
         cz_ff        <= cz_in;
         cnn_ff       <= cnn_in;
         halt_ff      <= halt_in;
         wb_valid_ff  <= wb_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff       <= s1_in;
      out_data_ff <= out_data_in;
      wb_idx_ff   <= wb_idx_in;
      wb_val_ff   <= wb_val_in;
      if (s2_adv) begin
         s2_ff <= s2_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

FILE: sv/ase_regfile.sv
// ----------------------------------------------------------------------------
// ase_regfile
// General register file, r0 to r14: two registered read ports, one write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ase_regfile (
   input  logic                 clock,
   input  logic [3:0]           rd_addr0,
   input  logic [3:0]           rd_addr1,
   output logic [31:0]          rd_data0,
   output logic [31:0]          rd_data1,
   input  ase_pkg::rf_wr_type   wr
);
   import ase_pkg::*;

   logic [31:0] regs [REG_COUNT];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         regs[wr.idx] <= wr.value;
      end
   end

   // the pc slot is not stored here; the caller substitutes it
   always_ff @(posedge clock) begin
      rd_data0 <= (rd_addr0 == REG_PC_IDX) ? '0 : regs[rd_addr0];
      rd_data1 <= (rd_addr1 == REG_PC_IDX) ? '0 : regs[rd_addr1];
   end

endmodule

`default_nettype wire

FILE: sv/ase_data_mem.sv
// ----------------------------------------------------------------------------
// ase_data_mem
// Word data memory, one port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ase_data_mem (
   input  logic                 clock,
   input  ase_pkg::dm_req_type  req,
   output logic [31:0]          rdata
);
   import ase_pkg::*;

   logic [31:0] words [DATA_WORDS];

   always_ff @(posedge clock) begin
      if (req.we) begin
         words[req.addr] <= req.wdata;
      end
   end

   // hold read data unless a new read is issued
   always_ff @(posedge clock) begin
      if (req.re) begin
         rdata <= words[req.addr];
      end
   end

endmodule

`default_nettype wire

FILE: sv/ase_csr.sv
// ----------------------------------------------------------------------------
// ase_csr
// Control registers behind the APB-style port: code_base and data_base.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ase_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ase_pkg::CSR_AW-1:0]    paddr,
   input  logic [ase_pkg::CSR_DW-1:0]    pwdata,
   output logic [ase_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready,
   output logic [23:0]                   data_base
);
   import ase_pkg::*;

   logic [15:0] code_base_ff, code_base_in;
   logic [23:0] data_base_ff, data_base_in;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      code_base_in = code_base_ff;
      data_base_in = data_base_ff;
      if (wr_en) begin
         unique case (paddr[2])
            CSR_SEL_CODE_BASE: code_base_in = pwdata[15:0];
            CSR_SEL_DATA_BASE: data_base_in = pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_base_ff <= CODE_BASE_RESET;
         data_base_ff <= DATA_BASE_RESET;
      end else begin
         code_base_ff <= code_base_in;
         data_base_ff <= data_base_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         CSR_SEL_CODE_BASE: prdata = {16'b0, code_base_ff};
         CSR_SEL_DATA_BASE: prdata = {8'b0, data_base_ff};
         default:           prdata = '0;
      endcase
   end

   assign data_base = data_base_ff;

endmodule

`default_nettype wire

FILE: sv/ase_checker.sv
// ----------------------------------------------------------------------------
// ase_checker
// Port-level checks of the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "arm_subset_execute_unit_defines.svh"

module ase_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [ase_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import ase_pkg::*;

   // clearing sweep and empty pipeline follow every reset
   `ASE_ASSERT_AFTER_RESET(a_reset_quiet, !req_tready && !rsp_tvalid, "busy after reset")

   // stalled result word holds
   `ASE_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp word changed under stall")

   // a halted step touches nothing
   `ASE_ASSERT_NOW(a_halt_idle, rsp_tvalid && rsp_tdata[RSP_HALT_BIT], !rsp_tdata[RSP_TAKEN_BIT] && !rsp_tdata[RSP_WR_BIT] && !rsp_tdata[RSP_MW_BIT] && !rsp_tdata[RSP_FAULT_BIT], "halted step had effects")

   // a faulting access stores nothing and reports word zero
   `ASE_ASSERT_NOW(a_fault_clean, rsp_tvalid && rsp_tdata[RSP_FAULT_BIT], !rsp_tdata[RSP_MW_BIT] && !rsp_tdata[RSP_WR_BIT] && (rsp_tdata[RSP_MIDX_LSB +: DMEM_AW] == '0), "fault with access")

endmodule

bind arm_subset_execute_unit ase_checker u_ase_checker (.*);

`default_nettype wire

FILE: verif/arm_subset_execute_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_subset_execute_unit_checker
// Watches the instruction, result and control ports of the execute unit.
// Each accepted instruction is run through an architectural model of the
// register file, pc, data memory and compare flags. The outcome is queued and
// compared field by field with the next result word that leaves the block.
// ----------------------------------------------------------------------------

module arm_subset_execute_unit_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [ase_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [ase_pkg::REQ_USER_W-1:0]  req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [ase_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ase_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [ase_pkg::CSR_DW-1:0]      csr_pwdata,
   input  logic                            csr_pready,
   output int                              failures,
   output int                              outstanding,
   output int                              checked
);
   import ase_pkg::*;

   typedef struct packed {
      logic [15:0]        next_pc;
      logic               wr;
      logic [3:0]         idx;
      logic [31:0]        value;
      logic               mw;
      logic [DMEM_AW-1:0] midx;
      logic               taken;
      logic               fault;
      logic               halted;
   } outcome_type;

   // architectural state
   logic [31:0] gpr [0:REG_COUNT-1];
   logic [31:0] dmem [0:DATA_WORDS-1];
   logic [15:0] pc;
   logic        cmp_zero;
   logic        cmp_nonneg;
   logic        halted;
   logic [23:0] data_base;

   outcome_type expected_outcomes [$];
   int          mismatch_count = 0;
   int          result_count = 0;

   assign failures = mismatch_count;
   assign checked  = result_count;

   function automatic logic [31:0] read_gpr(input logic [3:0] idx);
      if (idx == REG_PC_IDX) return {16'h0000, pc};
      return gpr[idx];
   endfunction

   function automatic outcome_type execute_insn(input insn_type ins);
      outcome_type o;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] diff;
      logic [31:0] addr;
      logic [31:0] off;
      o = '0;
      o.next_pc = pc + 16'd4;
      if (halted) begin
         o.next_pc = pc;
         o.halted = 1'b1;
         return o;
      end
      a = ins.a_is_imm ? ins.a_value : read_gpr(ins.a_value[3:0]);
      b = ins.b_is_imm ? ins.b_value : read_gpr(ins.b_value[3:0]);
      case (ins.op)
         OP_MOV: begin
            o.wr = 1'b1; o.idx = ins.dest; o.value = a;
         end
         OP_ADD: begin
            o.wr = 1'b1; o.idx = ins.dest; o.value = a + b;
         end
         OP_SUB: begin
            o.wr = 1'b1; o.idx = ins.dest; o.value = a - b;
         end
         OP_MUL: begin
            o.wr = 1'b1; o.idx = ins.dest; o.value = a * b;
         end
         OP_CMP: begin
            diff = read_gpr(ins.dest) - a;
            cmp_zero = (diff == 32'h0);
            cmp_nonneg = !diff[31];
         end
         OP_LDR, OP_STR: begin
            // base register and byte offset ignore the immediate flags
            addr = read_gpr(ins.a_value[3:0]) + ins.b_value;
            off = addr - {8'h00, data_base};
            if (off >= DMEM_BYTES) begin
               o.fault = 1'b1;
            end else begin
               o.midx = off[DMEM_AW+1:2];
               if (ins.op == OP_LDR) begin
                  o.wr = 1'b1; o.idx = ins.dest; o.value = dmem[o.midx];
               end else begin
                  dmem[o.midx] = read_gpr(ins.dest);
                  o.mw = 1'b1;
               end
            end
         end
         OP_LDRA: begin
            o.wr = 1'b1;
            o.idx = ins.dest;
            o.value = {8'h00, data_base} + {14'h0000, ins.target, 2'b00};
         end
         OP_B: o.taken = 1'b1;
         OP_BL: begin
            o.wr = 1'b1; o.idx = REG_LINK_IDX; o.value = {16'h0000, o.next_pc};
            o.taken = 1'b1;
         end
         OP_BNE: o.taken = !cmp_zero;
         OP_BGE: o.taken = cmp_nonneg;
         OP_EXIT: begin
            halted = 1'b1;
            o.next_pc = pc;
         end
         default: ;
      endcase
      if (o.wr) begin
         // drop writes aimed at the pc slot
         if (o.idx == REG_PC_IDX) begin
            o.wr = 1'b0; o.idx = '0; o.value = '0;
         end else begin
            gpr[o.idx] = o.value;
         end
      end
      if (o.taken) o.next_pc = ins.target;
      pc = o.next_pc;
      o.halted = halted;
      return o;
   endfunction

   function automatic int field_diff(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
      if (want === got) return 0;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      outcome_type pred;
      insn_type    ins;
      int          errs;
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) gpr[i] = '0;
         for (int i = 0; i < DATA_WORDS; i++) dmem[i] = '0;
         data_base = DATA_BASE_RESET;
         pc = CODE_BASE_RESET;
         cmp_zero = 1'b0;
         cmp_nonneg = 1'b0;
         halted = 1'b0;
         expected_outcomes.delete();
         outstanding <= 0;
      end else begin
         // code_base only matters at reset, which always restores its default
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == CSR_SEL_DATA_BASE) begin
            data_base = csr_pwdata[23:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            got.next_pc = rsp_tdata[RSP_PC_LSB +: 16];
            got.wr      = rsp_tdata[RSP_WR_BIT];
            got.idx     = rsp_tdata[RSP_IDX_LSB +: 4];
            got.value   = rsp_tdata[RSP_VAL_LSB +: 32];
            got.mw      = rsp_tdata[RSP_MW_BIT];
            got.midx    = rsp_tdata[RSP_MIDX_LSB +: DMEM_AW];
            got.taken   = rsp_tdata[RSP_TAKEN_BIT];
            got.fault   = rsp_tdata[RSP_FAULT_BIT];
            got.halted  = rsp_tdata[RSP_HALT_BIT];
            if (expected_outcomes.size() == 0) begin
               $display("%0t: result word with no instruction pending, %s 0x%0h",
                        $time, "expected none, actual", rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_outcomes.pop_front();
               errs = field_diff("next_pc", want.next_pc, got.next_pc)
                    + field_diff("reg_written", want.wr, got.wr)
                    + field_diff("reg_index", want.idx, got.idx)
                    + field_diff("reg_value", want.value, got.value)
                    + field_diff("mem_written", want.mw, got.mw)
                    + field_diff("mem_index", want.midx, got.midx)
                    + field_diff("branch_taken", want.taken, got.taken)
                    + field_diff("fault", want.fault, got.fault)
                    + field_diff("halted", want.halted, got.halted);
               mismatch_count += errs;
            end
            result_count++;
         end
         if (req_tvalid && req_tready) begin
            ins.op       = req_tuser[USER_OP_LSB +: 4];
            ins.a_is_imm = req_tuser[USER_AIMM_BIT];
            ins.b_is_imm = req_tuser[USER_BIMM_BIT];
            ins.dest     = req_tdata[REQ_DEST_LSB +: 4];
            ins.a_value  = req_tdata[REQ_A_LSB +: 32];
            ins.b_value  = req_tdata[REQ_B_LSB +: 32];
            ins.target   = req_tdata[REQ_TGT_LSB +: 16];
            pred = execute_insn(ins);
            // append at the tail
            expected_outcomes.insert(expected_outcomes.size(), pred);
         end
         outstanding <= expected_outcomes.size();
      end
   end

endmodule

FILE: verif/arm_subset_execute_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_subset_execute_unit_tb
// Instruction stream test of the execute unit.
// A directed program hits operand extremes, wrap-around, the pc as operand,
// dropped pc writes, flags before and after compares, branches and memory
// faults. Random phases under different data_base settings then mix pointer
// walks through data memory, compare-branch pairs and arbitrary instructions,
// with random gaps on both channels. The run closes with exit and a few
// instructions that must see the halted state.
// ----------------------------------------------------------------------------

module arm_subset_execute_unit_tb;
   import ase_pkg::*;

   localparam int         CLOCK_HALF   = 4;
   localparam int         RESET_CYCLES = 6;
   localparam int         CYCLE_LIMIT  = 700000;
   localparam int         PHASE_WORDS  = 330;
   localparam logic [3:0] OP_LABEL     = 4'd13;
   localparam logic [3:0] OP_SPARE     = 4'd15;
   localparam logic       IMM          = 1'b1;
   localparam logic       REG          = 1'b0;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic [REQ_USER_W-1:0] req_tuser   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]     csr_paddr   = '0;
   logic [CSR_DW-1:0]     csr_pwdata  = '0;
   logic [CSR_DW-1:0]     csr_prdata;
   logic                  csr_pready;

   int          failures;
   int          outstanding;
   int          checked;
   int          cycle_count   = 0;
   int          sent_count    = 0;
   int          walk_count    = 0;
   int          pair_count    = 0;
   int          setting_count = 0;
   int unsigned tx_burst      = 0;
   int unsigned rx_hold       = 0;
   int unsigned rx_free       = 0;

   always #CLOCK_HALF clock = ~clock;

   arm_subset_execute_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   arm_subset_execute_unit_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .failures    (failures),
      .outstanding (outstanding),
      .checked     (checked)
   );

   function automatic int unsigned gap_len();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'h0000_0001;
         2: return 32'hFFFF_FFFF;
         3: return 32'h7FFF_FFFF;
         4: return 32'h8000_0000;
         5: return 32'($urandom_range(0, 255));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] word_index();
      if ($urandom_range(0, 9) == 0) return 16'($urandom);
      return 16'($urandom_range(0, DATA_WORDS - 1));
   endfunction

   function automatic logic [31:0] byte_offset();
      if ($urandom_range(0, 7) == 0) return $urandom;
      // mostly just around the valid window, both sides
      return 32'($urandom_range(0, 4 * DATA_WORDS + 12)) - 32'd8;
   endfunction

   function automatic insn_type make_insn(input logic [3:0] op, input logic [3:0] dest,
                                          input logic a_imm, input logic [31:0] a_val,
                                          input logic b_imm, input logic [31:0] b_val,
                                          input logic [15:0] tgt);
      insn_type ins;
      ins.op       = op;
      ins.dest     = dest;
      ins.a_is_imm = a_imm;
      ins.a_value  = a_val;
      ins.b_is_imm = b_imm;
      ins.b_value  = b_val;
      ins.target   = tgt;
      return ins;
   endfunction

   // receiver: random stalls with occasional stall-free stretches
   always @(posedge clock) begin
      if (rx_hold != 0) begin
         rsp_tready <= 1'b0;
         rx_hold <= rx_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (rx_free != 0) rx_free <= rx_free - 1;
         else if ($urandom_range(0, 3) == 0) rx_hold <= gap_len();
         else if ($urandom_range(0, 30) == 0) rx_free <= $urandom_range(20, 100);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results pending", cycle_count, outstanding);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // call at a clock edge; returns at the edge that takes the word
   task automatic issue(input insn_type ins);
      int unsigned           gap;
      logic [REQ_DATA_W-1:0] word;
      logic [REQ_USER_W-1:0] side;
      gap = 0;
      if (tx_burst != 0) begin
         tx_burst--;
      end else begin
         gap = gap_len();
         if ($urandom_range(0, 40) == 0) tx_burst = $urandom_range(20, 80);
      end
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      word = '0;
      word[REQ_DEST_LSB +: 4] = ins.dest;
      word[REQ_A_LSB +: 32]   = ins.a_value;
      word[REQ_B_LSB +: 32]   = ins.b_value;
      word[REQ_TGT_LSB +: 16] = ins.target;
      side = '0;
      side[USER_OP_LSB +: 4]  = ins.op;
      side[USER_AIMM_BIT]     = ins.a_is_imm;
      side[USER_BIMM_BIT]     = ins.b_is_imm;
      req_tvalid <= 1'b1;
      req_tdata <= word;
      req_tuser <= side;
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   // call right after issue; the extra edge lets the last word reach the queue
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_config(input logic [15:0] code_base, input logic [23:0] data_base);
      for (int i = 0; i < 2; i++) begin
         csr_psel <= 1'b1;
         csr_pwrite <= 1'b1;
         csr_penable <= 1'b0;
         csr_paddr <= {(i == 0) ? CSR_SEL_CODE_BASE : CSR_SEL_DATA_BASE, 2'b00};
         csr_pwdata <= (i == 0) ? {16'h0000, code_base} : {8'h00, data_base};
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      setting_count++;
   endtask

   task automatic rand_operand(output logic imm, output logic [31:0] value);
      imm = 1'($urandom_range(0, 1));
      value = imm ? pick_value() : $urandom;
   endtask

   task automatic issue_random(input logic [3:0] op);
      logic        a_imm;
      logic        b_imm;
      logic [31:0] a_val;
      logic [31:0] b_val;
      rand_operand(a_imm, a_val);
      rand_operand(b_imm, b_val);
      issue(make_insn(op, 4'($urandom_range(0, 15)), a_imm, a_val, b_imm, b_val,
                      16'($urandom)));
   endtask

   task automatic random_phase(input int count);
      int         done;
      int         roll;
      int         n;
      logic [3:0] ptr;
      logic [3:0] op;
      done = 0;
      while (done < count) begin
         roll = $urandom_range(0, 99);
         if (roll < 30) begin
            // point a register into data memory, then load and store through it
            ptr = 4'($urandom_range(0, 14));
            issue(make_insn(OP_LDRA, ptr, 1'($urandom), $urandom, 1'($urandom), $urandom,
                            word_index()));
            n = $urandom_range(2, 6);
            for (int k = 0; k < n; k++)
               issue(make_insn($urandom_range(0, 1) ? OP_LDR : OP_STR,
                               4'($urandom_range(0, 15)), 1'($urandom),
                               {28'($urandom), ptr}, 1'($urandom), byte_offset(),
                               16'($urandom)));
            done += n + 1;
            walk_count++;
         end else if (roll < 50) begin
            issue_random(OP_CMP);
            issue_random($urandom_range(0, 1) ? OP_BNE : OP_BGE);
            done += 2;
            pair_count++;
         end else begin
            do op = 4'($urandom_range(0, 15)); while (op == OP_EXIT);
            issue_random(op);
            done++;
         end
         if ($urandom_range(0, 149) == 0) drain();
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // flags are clear before the first compare
      issue(make_insn(OP_BNE, 4'd0, IMM, 32'd0, IMM, 32'd0, 16'h0100));
      issue(make_insn(OP_BGE, 4'd0, IMM, 32'd0, IMM, 32'd0, 16'h0200));
      issue(make_insn(OP_MOV, 4'd0, IMM, 32'h7FFF_FFFF, IMM, 32'd0, 16'h0000));
      issue(make_insn(OP_MOV, 4'd1, IMM, 32'h8000_0000, REG, 32'd0, 16'h0000));
      issue(make_insn(OP_ADD, 4'd2, REG, 32'd0, REG, 32'd1, 16'h0000));
      issue(make_insn(OP_ADD, 4'd3, REG, 32'd0, IMM, 32'd1, 16'h0000));
      issue(make_insn(OP_SUB, 4'd4, REG, 32'd1, IMM, 32'd1, 16'h0000));
      issue(make_insn(OP_MUL, 4'd5, REG, 32'd0, IMM, 32'hFFFF_FFFF, 16'h0000));
      issue(make_insn(OP_MOV, 4'd6, REG, 32'hFFFF_FFFF, IMM, 32'd0, 16'h0000));
      // the pc slot takes no writes
      issue(make_insn(OP_ADD, REG_PC_IDX, REG, 32'd0, IMM, 32'd1, 16'h0000));
      issue(make_insn(OP_CMP, 4'd0, REG, 32'd0, IMM, 32'd0, 16'h0000));
      issue(make_insn(OP_BNE, 4'd0, IMM, 32'd0, IMM, 32'd0, 16'h0300));
      issue(make_insn(OP_BGE, 4'd0, IMM, 32'd0, IMM, 32'd0, 16'hFFFE));
      // pc wraps past the top of the code space here
      issue(make_insn(OP_MOV, 4'd7, IMM, 32'd0, IMM, 32'd0, 16'h0000));
      issue(make_insn(OP_CMP, 4'd0, IMM, 32'hFFFF_FFFF, IMM, 32'd0, 16'h0000));
      issue(make_insn(OP_BGE, 4'd0, IMM, 32'd0, IMM, 32'd0, 16'h0400));
      issue(make_insn(OP_BL, 4'd3, IMM, 32'd0, IMM, 32'd0, 16'hFFFF));
      issue(make_insn(OP_B, 4'd0, IMM, 32'd0, IMM, 32'd0, 16'h03E8));
      issue(make_insn(OP_LDRA, 4'd8, IMM, 32'd0, IMM, 32'd0, 16'h0000));
      issue(make_insn(OP_STR, 4'd1, REG, 32'd8, IMM, 32'd0, 16'h0000));
      // unaligned store of the pc into the last word
      issue(make_insn(OP_STR, REG_PC_IDX, REG, 32'd8, IMM, 32'd511, 16'h0000));
      issue(make_insn(OP_LDR, 4'd9, REG, 32'd8, IMM, 32'd0, 16'h0000));
      issue(make_insn(OP_LDR, 4'd10, REG, 32'd8, IMM, 32'd508, 16'h0000));
      issue(make_insn(OP_LDR, 4'd11, REG, 32'd8, IMM, 32'd512, 16'h0000));
      issue(make_insn(OP_STR, 4'd0, REG, 32'd8, IMM, 32'hFFFF_FFFF, 16'h0000));
      issue(make_insn(OP_LDRA, 4'd12, IMM, 32'd0, IMM, 32'd0, 16'hFFFF));
      issue(make_insn(OP_LABEL, 4'd2, IMM, 32'd0, IMM, 32'd0, 16'h0000));
      issue(make_insn(OP_SPARE, 4'd2, IMM, 32'd0, IMM, 32'd0, 16'h0000));
      drain();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: write_config(16'h0000, 24'h00_0000);
            1: write_config(16'hFFFF, 24'hFF_FFFF);
            2: write_config(16'($urandom), 24'($urandom));
            default: write_config(16'($urandom), DATA_BASE_RESET);
         endcase
         random_phase(PHASE_WORDS);
         drain();
      end

      // halt, then words that must find the unit halted
      issue(make_insn(OP_EXIT, 4'd0, IMM, 32'd0, IMM, 32'd0, 16'h0000));
      repeat (3) issue_random(4'($urandom_range(0, 15)));
      drain();
      repeat (10) @(posedge clock);

      $display("Sent %0d instructions, checked %0d results: %0d memory walks, %0d compare-branch pairs.",
               sent_count, checked, walk_count, pair_count);
      $display("Reset bases plus %0d written base pairs, extremes included; run closed on exit.",
               setting_count);
      if (outstanding != 0) $display("%0d results never arrived", outstanding);
      if (failures == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+sv
sv/ase_pkg.sv
sv/ase_regfile.sv
sv/ase_data_mem.sv
sv/ase_csr.sv
sv/arm_subset_execute_unit.sv
sv/ase_checker.sv
verif/arm_subset_execute_unit_checker.sv
verif/arm_subset_execute_unit_tb.sv
